// ===== rtl/stack_expression_evaluator_assert.svh =====
// Assertion macros used by the stack expression evaluator core module
`ifndef STACK_EXPRESSION_EVALUATOR_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define SEE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/see_pkg.sv =====
// Package with types and constants for the stack expression evaluator
package see_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int STORE_SLOTS = 16;
   localparam int DATA_WIDTH  = 64;

   localparam int OPERAND_W = 64;
   localparam int RESULT_W  = 64;
   localparam int SLOT_W    = 4;
   localparam int TDATA_W   = 72;

   localparam int SP_W     = $clog2(STACK_DEPTH + 1);
   localparam int MEM_AW   = $clog2(STACK_DEPTH);
   localparam int SLOT_AW  = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
   localparam int HALF_W   = DATA_WIDTH / 2;
   localparam int HI_W     = DATA_WIDTH - HALF_W;
   localparam int LL_W     = 2 * HALF_W;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EXEC  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      OP_CONST = 3'd0,
      OP_LOAD  = 3'd1,
      OP_NEG   = 3'd2,
      OP_ADD   = 3'd3,
      OP_SUB   = 3'd4,
      OP_MUL   = 3'd5,
      OP_MIN   = 3'd6,
      OP_MAX   = 3'd7
   } opcode_type;

   typedef struct packed {
      logic                valid;
      logic [RESULT_W-1:0] result;
      logic                stack_error;
   } rsp_type;

endpackage

// ===== rtl/stack_expression_evaluator.sv =====
// Top level of the stack expression evaluator
// Usage:
//  - req channel: one transaction per item. tuser is the command (store write or
//    execute), tlast marks the final instruction of an expression.
//  - rsp channel: one transaction per final instruction, carrying the top of stack
//    (zero when empty) in tdata and the expression's stack fault flag in tuser.
//  - Throughput: one transaction per cycle while the result queue has space, for
//    every opcode except mul, which holds off further input while its partial
//    products are registered before the sum (req_tready drops while busy).
//  - The result of a final instruction is registered into the result queue on
//    acceptance; that of a final mul once its sum is formed in the busy state.
//  - The top two stack entries sit in registers, deeper ones in a one-write,
//    one-read memory with a registered read prefetched under next-of-stack.
//  - Reset clears the stack pointer, fault flag, value store and result queue;
//    no clearing pass is needed.
//  - A two-entry result queue lets input flow while a result waits; when the
//    receiver stalls with both entries full, req_tready goes low.
module stack_expression_evaluator
   import see_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // opcode[2:0], operand[66:3], slot[70:67], pad
   input  logic                req_tuser,   // command
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RESULT_W-1:0] rsp_tdata,   // result[63:0]
   output logic                rsp_tuser    // stack_error
);

   logic                  req_acc;
   command_type           cmd;
   opcode_type            op;
   logic [OPERAND_W-1:0]  operand;
   logic [SLOT_W-1:0]     slot;
   logic [DATA_WIDTH-1:0] load_data;
   logic [DATA_WIDTH-1:0] mul_product;
   logic [DATA_WIDTH-1:0] mul_a;
   logic [DATA_WIDTH-1:0] mul_b;
   logic                  mul_start;
   logic                  busy;
   logic                  space;
   rsp_type               rsp;

   assign cmd        = command_type'(req_tuser);
   assign op         = opcode_type'(req_tdata[2:0]);
   assign operand    = req_tdata[66:3];
   assign slot       = req_tdata[70:67];
   assign req_tready = space && !busy;
   assign req_acc    = req_tvalid && req_tready;

   see_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (req_acc && cmd == CMD_WRITE),
      .wr_slot    (slot),
      .wr_data    (operand[DATA_WIDTH-1:0]),
      .rd_operand (operand),
      .rd_data    (load_data)
   );

   see_mul u_mul (
      .clock   (clock),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_product)
   );

   see_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_acc     (req_acc),
      .cmd         (cmd),
      .op          (op),
      .data        (operand[DATA_WIDTH-1:0]),
      .last        (req_tlast),
      .load_data   (load_data),
      .mul_product (mul_product),
      .mul_start   (mul_start),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .busy        (busy),
      .rsp         (rsp)
   );

   see_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/see_store.sv =====
// Value store: slot registers with one write port and one load read port
module see_store
   import see_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [SLOT_W-1:0]     wr_slot,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [OPERAND_W-1:0]  rd_operand,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [STORE_SLOTS];
   logic                  wr_hit;
   logic                  rd_hit;

   assign wr_hit = wr_en && (32'(wr_slot) < STORE_SLOTS);
   assign rd_hit = !rd_operand[OPERAND_W-1] && (rd_operand < OPERAND_W'(STORE_SLOTS));
   assign rd_data = rd_hit ? store_ff[SLOT_AW'(rd_operand)] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         store_ff[SLOT_AW'(wr_slot)] <= wr_data;
      end
   end

endmodule

// ===== rtl/see_mul.sv =====
// Wrapping multiplier: registered partial products, then a sum
module see_mul
   import see_pkg::*;
(
   input  logic                  clock,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output logic [DATA_WIDTH-1:0] product
);

   logic [LL_W-1:0] ll_ff;
   logic [HI_W-1:0] c1_ff;
   logic [HI_W-1:0] c2_ff;
   logic [HI_W-1:0] cross_sum;

   always_ff @(posedge clock) begin
      if (start) begin
         ll_ff <= LL_W'(a[HALF_W-1:0]) * LL_W'(b[HALF_W-1:0]);
         c1_ff <= HI_W'(a[HALF_W-1:0]) * b[DATA_WIDTH-1:HALF_W];
         c2_ff <= a[DATA_WIDTH-1:HALF_W] * HI_W'(b[HALF_W-1:0]);
      end
   end

   // only the low half of each cross term reaches the wrapped product
   assign cross_sum = c1_ff + c2_ff;
   assign product   = DATA_WIDTH'(ll_ff) + (DATA_WIDTH'(cross_sum) << HALF_W);

endmodule

// ===== rtl/see_core.sv =====
// Stack engine: cached top two entries, deeper entries in a memory, ALU
module see_core
   import see_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_acc,
   input  command_type           cmd,
   input  opcode_type            op,
   input  logic [DATA_WIDTH-1:0] data,
   input  logic                  last,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] mul_product,
   output logic                  mul_start,
   output logic [DATA_WIDTH-1:0] mul_a,
   output logic [DATA_WIDTH-1:0] mul_b,
   output logic                  busy,
   output rsp_type               rsp
);

`include "stack_expression_evaluator_assert.svh"

   logic [SP_W-1:0]       sp_ff, sp_in;
   logic [DATA_WIDTH-1:0] tos_ff, tos_in;
   logic [DATA_WIDTH-1:0] nos_ff, nos_in;
   logic [DATA_WIDTH-1:0] rd_ff;
   logic                  err_ff, err_in;
   logic                  busy_ff, busy_in;
   logic                  mlast_ff, mlast_in;
   logic [DATA_WIDTH-1:0] stack_mem_ff [STACK_DEPTH];

   logic                  wr_en;
   logic [MEM_AW-1:0]     wr_addr;
   logic [MEM_AW-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] alu_r;
   logic [DATA_WIDTH-1:0] push_val;
   logic                  emit;

   assign busy     = busy_ff;
   assign mul_a    = nos_ff;
   assign mul_b    = tos_ff;
   assign push_val = (op == OP_CONST) ? data : load_data;
   assign wr_addr  = MEM_AW'(sp_ff - SP_W'(2));

   always_comb begin
      unique case (op)
         OP_ADD:  alu_r = nos_ff + tos_ff;
         OP_SUB:  alu_r = nos_ff - tos_ff;
         OP_MIN:  alu_r = ($signed(tos_ff) < $signed(nos_ff)) ? tos_ff : nos_ff;
         OP_MAX:  alu_r = ($signed(nos_ff) < $signed(tos_ff)) ? tos_ff : nos_ff;
         default: alu_r = '0;
      endcase
   end

   always_comb begin
      sp_in     = sp_ff;
      tos_in    = tos_ff;
      nos_in    = nos_ff;
      err_in    = err_ff;
      busy_in   = 1'b0;
      mlast_in  = mlast_ff;
      wr_en     = 1'b0;
      mul_start = 1'b0;
      emit      = 1'b0;
      rsp       = '0;
      if (busy_ff) begin
         tos_in = mul_product;
         emit   = mlast_ff;
      end else if (req_acc && cmd == CMD_EXEC) begin
         unique case (op)
            OP_CONST, OP_LOAD: begin
               if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                  err_in = 1'b1;
               end else begin
                  tos_in = push_val;
                  nos_in = tos_ff;
                  wr_en  = (sp_ff >= SP_W'(2));
                  sp_in  = sp_ff + SP_W'(1);
               end
            end
            OP_NEG: begin
               if (sp_ff == '0) begin
                  err_in = 1'b1;
               end else begin
                  tos_in = '0 - tos_ff;
               end
            end
            default: begin
               if (sp_ff < SP_W'(2)) begin
                  err_in = 1'b1;
               end else begin
                  sp_in  = sp_ff - SP_W'(1);
                  nos_in = rd_ff;
                  if (op == OP_MUL) begin
                     mul_start = 1'b1;
                     busy_in   = 1'b1;
                     mlast_in  = last;
                  end else begin
                     tos_in = alu_r;
                  end
               end
            end
         endcase
         emit = last && !mul_start;
      end
      if (emit) begin
         rsp.valid       = 1'b1;
         rsp.result      = (sp_in != '0) ? RESULT_W'($signed(tos_in)) : '0;
         rsp.stack_error = err_in;
         sp_in           = '0;
         err_in          = 1'b0;
      end
   end

   // rd_ff always holds the entry just below next-of-stack
   assign rd_addr = MEM_AW'(sp_in - SP_W'(3));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= nos_ff;
      end
      rd_ff  <= (wr_en && wr_addr == rd_addr) ? nos_ff : stack_mem_ff[rd_addr];
      tos_ff <= tos_in;
      nos_ff <= nos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         err_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         mlast_ff <= 1'b0;
      end else begin
         sp_ff    <= sp_in;
         err_ff   <= err_in;
         busy_ff  <= busy_in;
         mlast_ff <= mlast_in;
      end
   end

   `SEE_ASSERT_NOW(a_sp_range, 1'b1, sp_ff <= SP_W'(STACK_DEPTH), "stack pointer past depth")
   `SEE_ASSERT_NEXT(a_mul_one_cycle, busy_ff, !busy_ff, "multiply held busy twice")
   `SEE_ASSERT_NOW(a_no_accept_busy, busy_ff, !req_acc, "transaction accepted while busy")
   `SEE_ASSERT_NEXT(a_mul_last_clear, busy_ff && mlast_ff, sp_ff == '0 && !err_ff,
                    "stack not cleared after final multiply")

endmodule

// ===== rtl/see_out_buf.sv =====
// Two-entry result queue driving the response channel
module see_out_buf
   import see_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rsp_type             push,
   output logic                space,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RESULT_W-1:0] rsp_tdata,
   output logic                rsp_tuser
);

   rsp_type    ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign space      = (cnt_ff != 2'd2);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = ent_ff[rptr_ff].result;
   assign rsp_tuser  = ent_ff[rptr_ff].stack_error;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      wptr_in = wptr_ff ^ push.valid;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + 2'(push.valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         ent_ff[wptr_ff] <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
